/* hw/rtl/closeness_centrality_dijkstra_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef CLOSENESS_CENTRALITY_DIJKSTRA_CORE_DEFINES_SVH
`define CLOSENESS_CENTRALITY_DIJKSTRA_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ccd_pkg.sv */
`timescale 1ns / 1ps

package ccd_pkg;

	localparam int OP_W       = 1;
	localparam int NODE_FLD_W = 6;
	localparam int CLOS_W     = 32;
	localparam int SUMO_W     = 32;
	localparam int CNT_W      = 7;
	// closeness numerator is (present - 1) scaled by 2^16 (Q16.16) times 2^8 (Q24.8 sum)
	localparam int CLOS_SHIFT = 24;

	localparam logic [OP_W-1:0] OP_ADD_EDGE = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY    = 1'b1;

endpackage

/* hw/rtl/closeness_centrality_dijkstra_core.sv */
`timescale 1ns / 1ps
// Channel  Handshake                  Payload
// item     item_valid / item_stall    operation, edge_from, edge_to, edge_weight, source_node
// result   result_valid / result_stall closeness, distance_sum, reached_count, undefined_flag
//
// Edge load: read and compare of the adjacency entry; when it is updated, its write and
// then the mirrored write. Query: a settle-and-scan pass over the adjacency row memory
// for each reached node, then, for a nonzero distance sum, a bit-serial division over
// NUMW = clog2(MAX_NODES+1) + 24 quotient bits. The adjacency memory read port paces
// the scan. After reset a clearing pass over all 2^(2*clog2(MAX_NODES)) entries (4096)
// invalidates the adjacency memory, with item_stall high. A finished result waits in the
// output register while edge loads go on; a second query's result waits for it to be taken.
module closeness_centrality_dijkstra_core #(
	parameter int MAX_NODES   = 64,
	parameter int WEIGHT_BITS = 16,
	parameter int SUM_BITS    = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [ccd_pkg::OP_W-1:0]         operation,
	input  logic [ccd_pkg::NODE_FLD_W-1:0]   edge_from,
	input  logic [ccd_pkg::NODE_FLD_W-1:0]   edge_to,
	input  logic [WEIGHT_BITS-1:0]           edge_weight,
	input  logic [ccd_pkg::NODE_FLD_W-1:0]   source_node,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [ccd_pkg::CLOS_W-1:0]       closeness,
	output logic [ccd_pkg::SUMO_W-1:0]       distance_sum,
	output logic [ccd_pkg::CNT_W-1:0]        reached_count,
	output logic                             undefined_flag
);
	import ccd_pkg::*;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int CW      = $clog2(MAX_NODES + 1);
	localparam int DW      = WEIGHT_BITS + NODE_W;
	localparam int AW      = ((SUM_BITS > DW) ? SUM_BITS : DW) + 1;
	localparam int NUMW    = CW + CLOS_SHIFT;
	localparam int DCW     = $clog2(NUMW + 1);
	localparam int ADJ_AW  = 2 * NODE_W;
	localparam int ADJ_DEP = 1 << ADJ_AW;
	localparam int ENT_W   = WEIGHT_BITS + 1;
	localparam logic [NODE_W-1:0]   LAST_NODE = NODE_W'(MAX_NODES - 1);
	localparam logic [SUM_BITS-1:0] SUM_MAX   = '1;

	typedef enum logic [8:0] {
		S_CLEAR    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_EDGE_CMP = 9'b000000100,
		S_EDGE_WR2 = 9'b000001000,
		S_SETTLE   = 9'b000010000,
		S_SCAN     = 9'b000100000,
		S_DIV      = 9'b001000000,
		S_DONE     = 9'b010000000,
		S_SPARE    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [ENT_W-1:0]  adj_mem [ADJ_DEP];
	logic [ENT_W-1:0]  adj_rd_q;
	logic [ADJ_AW-1:0] adj_raddr, adj_waddr;
	logic [ENT_W-1:0]  adj_wdata;
	logic              adj_we;
	logic [ADJ_AW-1:0] clr_q;

	logic [DW-1:0]     dist_mem [MAX_NODES];
	logic [DW-1:0]     dist_rd_q;

	logic [MAX_NODES-1:0] present_q, reached_q, visited_q;
	logic [CW-1:0]        pcount_q, count_q;

	logic [NODE_W-1:0]      ea_q, eb_q, b_q, cnt_q, i_s1, min_idx_q;
	logic [WEIGHT_BITS-1:0] ew_q;
	logic [DW-1:0]          dist_b_q, min_val_q;
	logic                   issuing_q, vld_s1, found_q;
	logic [SUM_BITS-1:0]    sum_q, rem_q;
	logic [NUMW-1:0]        quo_q;
	logic [DCW-1:0]         dcnt_q;

	logic accept, from_ok, to_ok, src_ok, src_present, edge_upd;
	logic [NODE_W-1:0] a_n, b_n, src_n;
	logic new_a, new_b;

	logic          rel_upd, cand, take;
	logic [DW-1:0] nd, cval;

	logic [AW-1:0]       sum_add;
	logic [SUM_BITS-1:0] sum_next;

	logic [SUM_BITS:0]     rem_sh;
	logic                  div_ge;
	logic [SUM_BITS-1:0]   rem_nx;
	logic [NUMW-1:0]       num;
	logic [NUMW+CLOS_W-1:0] quo_ext;
	logic [CLOS_W-1:0]     clos_val;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;

	assign from_ok     = 32'(edge_from) < MAX_NODES;
	assign to_ok       = 32'(edge_to) < MAX_NODES;
	assign src_ok      = 32'(source_node) < MAX_NODES;
	assign a_n         = NODE_W'(edge_from);
	assign b_n         = NODE_W'(edge_to);
	assign src_n       = NODE_W'(source_node);
	assign src_present = src_ok && present_q[src_n];
	assign new_a       = !present_q[a_n];
	assign new_b       = !present_q[b_n] && (a_n != b_n);

	assign edge_upd = !adj_rd_q[WEIGHT_BITS] || (ew_q < adj_rd_q[WEIGHT_BITS-1:0]);

	// relax stage: one adjacency entry and one tentative distance per cycle
	assign nd      = dist_b_q + DW'(adj_rd_q[WEIGHT_BITS-1:0]);
	assign rel_upd = vld_s1 && adj_rd_q[WEIGHT_BITS] && !visited_q[i_s1] &&
	                 (!reached_q[i_s1] || nd < dist_rd_q);
	assign cval    = rel_upd ? nd : dist_rd_q;
	assign cand    = vld_s1 && !visited_q[i_s1] && (reached_q[i_s1] || rel_upd);
	assign take    = cand && (!found_q || cval < min_val_q);

	assign sum_add  = AW'(sum_q) + AW'(dist_b_q);
	assign sum_next = (sum_add > AW'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(sum_add);

	assign num      = {CW'(pcount_q - CW'(1)), {CLOS_SHIFT{1'b0}}};
	assign rem_sh   = {rem_q, quo_q[NUMW-1]};
	assign div_ge   = rem_sh >= {1'b0, sum_q};
	assign rem_nx   = div_ge ? SUM_BITS'(rem_sh - {1'b0, sum_q}) : SUM_BITS'(rem_sh);
	assign quo_ext  = (NUMW + CLOS_W)'(quo_q);
	assign clos_val = (|quo_ext[NUMW+CLOS_W-1:CLOS_W]) ? '1 : CLOS_W'(quo_q);

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = clr_q;
		adj_wdata = '0;
		adj_raddr = {a_n, b_n};
		unique case (state_q)
			S_CLEAR: adj_we = 1'b1;
			S_EDGE_CMP: begin
				adj_we    = edge_upd;
				adj_waddr = {ea_q, eb_q};
				adj_wdata = {1'b1, ew_q};
			end
			S_EDGE_WR2: begin
				adj_we    = 1'b1;
				adj_waddr = {eb_q, ea_q};
				adj_wdata = {1'b1, ew_q};
			end
			S_SCAN: adj_raddr = {b_q, cnt_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_we)
			adj_mem[adj_waddr] <= adj_wdata;
		adj_rd_q <= adj_mem[adj_raddr];
	end

	always_ff @(posedge clk) begin
		if (rel_upd)
			dist_mem[i_s1] <= nd;
		dist_rd_q <= dist_mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			present_q    <= '0;
			pcount_q     <= '0;
			reached_q    <= '0;
			visited_q    <= '0;
			issuing_q    <= 1'b0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				result_valid <= 1'b0;
			vld_s1 <= (state_q == S_SCAN) && issuing_q;
			i_s1   <= cnt_q;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_ADD_EDGE) begin
							if (from_ok && to_ok) begin
								present_q[a_n] <= 1'b1;
								present_q[b_n] <= 1'b1;
								pcount_q <= pcount_q + CW'(new_a) + CW'(new_b);
								ea_q     <= a_n;
								eb_q     <= b_n;
								ew_q     <= edge_weight;
								state_q  <= S_EDGE_CMP;
							end
						end else begin
							sum_q   <= '0;
							count_q <= '0;
							if (src_present) begin
								reached_q        <= '0;
								reached_q[src_n] <= 1'b1;
								visited_q        <= '0;
								b_q              <= src_n;
								dist_b_q         <= '0;
								state_q          <= S_SETTLE;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_EDGE_CMP: state_q <= edge_upd ? S_EDGE_WR2 : S_IDLE;
				S_EDGE_WR2: state_q <= S_IDLE;
				S_SETTLE: begin
					visited_q[b_q] <= 1'b1;
					sum_q     <= sum_next;
					count_q   <= count_q + 1'b1;
					cnt_q     <= '0;
					issuing_q <= 1'b1;
					found_q   <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (issuing_q) begin
						if (cnt_q == LAST_NODE)
							issuing_q <= 1'b0;
						else
							cnt_q <= cnt_q + 1'b1;
					end
					if (take) begin
						found_q   <= 1'b1;
						min_val_q <= cval;
						min_idx_q <= i_s1;
					end
					if (rel_upd)
						reached_q[i_s1] <= 1'b1;
					// row done: settle the nearest open node or finish
					if (!issuing_q && !vld_s1) begin
						if (found_q) begin
							b_q      <= min_idx_q;
							dist_b_q <= min_val_q;
							state_q  <= S_SETTLE;
						end else if (sum_q == '0) begin
							state_q <= S_DONE;
						end else begin
							quo_q   <= num;
							rem_q   <= '0;
							dcnt_q  <= DCW'(NUMW);
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q  <= rem_nx;
					quo_q  <= {quo_q[NUMW-2:0], div_ge};
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DCW'(1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!result_valid || !result_stall) begin
						result_valid   <= 1'b1;
						closeness      <= (sum_q == '0) ? '0 : clos_val;
						distance_sum   <= SUMO_W'(sum_q);
						reached_count  <= CNT_W'(count_q);
						undefined_flag <= (sum_q == '0);
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/ccd_checker.sv */
`timescale 1ns / 1ps
`include "closeness_centrality_dijkstra_core_defines.svh"

module ccd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [ccd_pkg::CLOS_W-1:0]  closeness,
	input logic [ccd_pkg::SUMO_W-1:0]  distance_sum,
	input logic [ccd_pkg::CNT_W-1:0]   reached_count,
	input logic                        undefined_flag
);

	`CCD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(closeness) && $stable(distance_sum) && $stable(undefined_flag), "result changed while stalled")
	`CCD_ASSERT_IMP(a_undef_zero, result_valid && undefined_flag, closeness == '0, "undefined result carries nonzero closeness")
	`CCD_ASSERT_IMP(a_def_reach, result_valid && !undefined_flag, reached_count > 7'd1, "defined result with fewer than two reached nodes")
	`CCD_ASSERT_IMP(a_absent_src, result_valid && reached_count == '0, undefined_flag && distance_sum == '0, "nothing reached but result defined")

endmodule

bind closeness_centrality_dijkstra_core ccd_checker u_ccd_checker (.*);
